/* rtl/core/rct_pkg.sv */
`default_nettype none

package rct_pkg;

    localparam int ID_W   = 32;
    localparam int SLOT_W = 3;
    localparam int HIT_W  = 8;
    localparam int SIZE_W = 4;

    localparam logic [HIT_W-1:0] MAX_HITS_RST = 8'd8;

    typedef struct packed {
        logic [ID_W-1:0] holder_id;
        logic [ID_W-1:0] owner_id;
        logic            has_holder;
        logic            batch_end;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [ID_W-1:0]   cand_id_out;
        logic [HIT_W-1:0]  hit_count;
        logic              entry_valid;
        logic [SIZE_W-1:0] table_size;
        logic              last_entry;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_BUBBLE,
        S_CLOSE,
        S_APPEND,
        S_DUMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic search;
        logic bubble_step;
        logic decay;
        logic close_start;
        logic append_step;
        logic clear_pending;
        logic dump_start;
        logic dump_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_take;
        logic batch_end;
        logic hit;
        logic inc_ok;
        logic bubble_more;
        logic decay_due;
        logic append_more;
        logic dump_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/core/ranked_candidate_table_unit.sv */
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_stall    o_out_item (t_out_item)
// config    in         i_cfg_we (no wait)           i_cfg_data (max_hits)
//
// An item without a batch end passes through the idle and search states;
// a counted hit adds the bubble state, which moves the entry toward the
// front. A batch end adds the close state, one append step per appended id,
// the dump start and one dump step per emitted transaction if not stalled.
// The controller runs one item at a time; the output register lets the next
// item enter while the last dump transaction is still waiting to be taken.
// Reset is synchronous and active low; it empties the table and the pending
// queue and loads max_hits with 8. No clearing pass is needed after reset.
module ranked_candidate_table_unit
    import rct_pkg::*;
#(
    parameter int CAND_SLOTS    = 8,
    parameter int PENDING_SLOTS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_we,
    input  wire logic [HIT_W-1:0] i_cfg_data
);

    // The controller sequences search, bubble, decay, append and dump; the
    // datapath holds the table, the pending queue and the output register.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    rct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rct_datapath #(
        .CAND_SLOTS    (CAND_SLOTS),
        .PENDING_SLOTS (PENDING_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* rtl/core/rct_ctrl.sv */
`default_nettype none

module rct_ctrl
    import rct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_status.needs_take) begin
                    o_cmd.search = 1'b1;
                end
                if (i_status.needs_take && i_status.hit && i_status.inc_ok) begin
                    n_state = S_BUBBLE;
                end else if (i_status.batch_end) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BUBBLE: begin
                if (i_status.bubble_more) begin
                    o_cmd.bubble_step = 1'b1;
                end else if (i_status.batch_end) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CLOSE: begin
                o_cmd.decay       = i_status.decay_due;
                o_cmd.close_start = 1'b1;
                n_state           = S_APPEND;
            end
            S_APPEND: begin
                if (i_status.append_more) begin
                    o_cmd.append_step = 1'b1;
                end else begin
                    o_cmd.clear_pending = 1'b1;
                    o_cmd.dump_start    = 1'b1;
                    n_state             = S_DUMP;
                end
            end
            S_DUMP: begin
                if (i_status.out_free) begin
                    o_cmd.dump_load = 1'b1;
                    if (i_status.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rct_datapath.sv */
`default_nettype none

module rct_datapath
    import rct_pkg::*;
#(
    parameter int CAND_SLOTS    = 8,
    parameter int PENDING_SLOTS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_in_item         i_in_item,
    input  wire logic             i_cfg_we,
    input  wire logic [HIT_W-1:0] i_cfg_data,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item
);

    localparam int CI = $clog2(CAND_SLOTS);
    localparam int CW = $clog2(CAND_SLOTS + 1);
    localparam int PI = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int PW = $clog2(PENDING_SLOTS + 1);

    t_in_item         r_item;
    logic [ID_W-1:0]  r_ids  [CAND_SLOTS];
    logic [HIT_W-1:0] r_hits [CAND_SLOTS];
    logic [ID_W-1:0]  r_pend [PENDING_SLOTS];
    logic [CW-1:0]    r_used;
    logic [PW-1:0]    r_pcount;
    logic [CI-1:0]    r_ptr;
    logic [PW-1:0]    r_app;
    logic [CW-1:0]    r_dump;
    logic [HIT_W-1:0] r_max_hits;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [CAND_SLOTS-1:0] w_match;
    logic [CAND_SLOTS-1:0] w_low;
    logic                  w_hit;
    logic [CI-1:0]         w_hit_idx;
    logic                  w_inc_ok;
    logic [CI-1:0]         w_ptr_prev;
    logic [HIT_W-1:0]      w_front;
    logic [CW-1:0]         w_idle;
    logic                  w_pend_room;
    logic                  w_dump_last;
    logic                  w_out_free;

    // Parallel compare of the holder against every live slot; the lowest
    // matching slot wins since the table may hold repeated ids.
    always_comb begin
        w_hit_idx = '0;
        for (int j = 0; j < CAND_SLOTS; j++) begin
            w_match[j] = (CW'(j) < r_used) && (r_ids[j] == r_item.holder_id);
            w_low[j]   = (CW'(j) < r_used) && (r_hits[j] <= 8'd1);
        end
        for (int j = CAND_SLOTS - 1; j >= 0; j--) begin
            if (w_match[j]) begin
                w_hit_idx = CI'(j);
            end
        end
    end

    assign w_hit       = |w_match;
    assign w_inc_ok    = r_hits[w_hit_idx] < r_max_hits;
    assign w_ptr_prev  = r_ptr - CI'(1);
    assign w_front     = (r_used != '0) ? r_hits[0] : '0;
    assign w_idle      = CW'($countones(w_low));
    assign w_pend_room = r_pcount < PW'(PENDING_SLOTS);
    assign w_dump_last = (r_used == '0) || ((r_dump + CW'(1)) >= r_used);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status.needs_take  = r_item.has_holder && (r_item.holder_id != r_item.owner_id);
        o_status.batch_end   = r_item.batch_end;
        o_status.hit         = w_hit;
        o_status.inc_ok      = w_inc_ok;
        o_status.bubble_more = (r_ptr != '0) && (r_hits[r_ptr] > r_hits[w_ptr_prev]);
        o_status.decay_due   = w_front == r_max_hits;
        o_status.append_more = (r_app < r_pcount) && (r_used < CW'(CAND_SLOTS));
        o_status.dump_last   = w_dump_last;
        o_status.out_free    = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_pcount    <= '0;
            r_out_valid <= 1'b0;
            r_max_hits  <= MAX_HITS_RST;
        end else begin
            if (i_cfg_we) begin
                r_max_hits <= i_cfg_data;
            end
            if (i_cmd.search && !w_hit && w_pend_room) begin
                r_pcount <= r_pcount + PW'(1);
            end
            if (i_cmd.clear_pending) begin
                r_pcount <= '0;
            end
            if (i_cmd.decay) begin
                r_used <= r_used - w_idle;
            end
            if (i_cmd.append_step) begin
                r_used <= r_used + CW'(1);
            end
            if (i_cmd.dump_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.search) begin
            if (w_hit) begin
                if (w_inc_ok) begin
                    r_hits[w_hit_idx] <= r_hits[w_hit_idx] + 8'd1;
                end
                r_ptr <= w_hit_idx;
            end else if (w_pend_room) begin
                r_pend[r_pcount[PI-1:0]] <= r_item.holder_id;
            end
        end
        if (i_cmd.bubble_step) begin
            r_ids[w_ptr_prev]  <= r_ids[r_ptr];
            r_hits[w_ptr_prev] <= r_hits[r_ptr];
            r_ids[r_ptr]       <= r_ids[w_ptr_prev];
            r_hits[r_ptr]      <= r_hits[w_ptr_prev];
            r_ptr              <= w_ptr_prev;
        end
        if (i_cmd.decay) begin
            for (int j = 0; j < CAND_SLOTS; j++) begin
                if (r_hits[j] != '0) begin
                    r_hits[j] <= r_hits[j] - 8'd1;
                end
            end
        end
        if (i_cmd.close_start) begin
            r_app <= '0;
        end
        if (i_cmd.append_step) begin
            r_ids[r_used[CI-1:0]]  <= r_pend[r_app[PI-1:0]];
            r_hits[r_used[CI-1:0]] <= 8'd1;
            r_app                  <= r_app + PW'(1);
        end
        if (i_cmd.dump_start) begin
            r_dump <= '0;
        end
        if (i_cmd.dump_load) begin
            if (r_used == '0) begin
                r_out.slot_index  <= '0;
                r_out.cand_id_out <= '0;
                r_out.hit_count   <= '0;
                r_out.entry_valid <= 1'b0;
                r_out.table_size  <= '0;
                r_out.last_entry  <= 1'b1;
            end else begin
                r_out.slot_index  <= SLOT_W'(r_dump);
                r_out.cand_id_out <= r_ids[r_dump[CI-1:0]];
                r_out.hit_count   <= r_hits[r_dump[CI-1:0]];
                r_out.entry_valid <= 1'b1;
                r_out.table_size  <= SIZE_W'(r_used);
                r_out.last_entry  <= w_dump_last;
            end
            r_dump <= r_dump + CW'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAND_SLOTS))
        else $error("candidate table holds more entries than it has slots");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= PW'(PENDING_SLOTS))
        else $error("pending queue count exceeds its depth");

    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.entry_valid) |-> (r_out.hit_count != '0))
        else $error("a reported table entry carries a zero hit count");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dump_load && w_dump_last) |=> (r_out_valid && r_out.last_entry))
        else $error("final dump transaction is missing its last flag");

endmodule

`default_nettype wire

/* verif/tb_ranked_candidate_table_unit.sv */
`timescale 1ns / 100ps

module tb_ranked_candidate_table_unit;
    import rct_pkg::*;

    localparam int SLOTS       = 8;
    localparam int QUEUE_SLOTS = 8;
    // Worst wait for a mid-batch item to settle: the search plus a full
    // bubble walk, rounded up generously.
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 120;
    localparam int POOL_N        = 12;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #6 i_clk = ~i_clk;

    // Every block input starts at a known value.
    logic             i_in_valid  = 1'b0;
    t_in_item         i_in_item   = '0;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [HIT_W-1:0] i_cfg_data  = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_item;

    ranked_candidate_table_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // Shared controls: random idling on both sides, and a request for a long
    // output hold-off that the receiving process counts out on its own.
    bit idle_on   = 1'b1;
    int hold_tag  = 0;
    int errors    = 0;
    int work_sent = 0;

    // The predicted ranked table, the queue of ids that are new in the open
    // batch, and the saturation limit that the block should hold.
    logic [ID_W-1:0]  table_ids  [SLOTS];
    logic [HIT_W-1:0] table_hits [SLOTS];
    int               table_used;
    logic [ID_W-1:0]  fresh_ids  [QUEUE_SLOTS];
    int               fresh_cnt;
    logic [HIT_W-1:0] hit_limit;

    // Dump transactions that are predicted but not yet seen on the output.
    t_out_item dump_expected [$];

    logic [ID_W-1:0] id_pool [POOL_N];

    // A holder that is already ranked gains one hit, unless it has reached
    // the limit, and then moves up past every entry with fewer hits. A holder
    // that is not ranked is queued as new while the queue has room; repeats
    // of a new id are queued again since only the ranked table is searched.
    function automatic void rank_holder(logic [ID_W-1:0] id);
        int j;
        logic [ID_W-1:0]  tid;
        logic [HIT_W-1:0] th;
        for (j = 0; j < table_used; j++) begin
            if (table_ids[j] == id) begin
                if (table_hits[j] < hit_limit) begin
                    table_hits[j] = table_hits[j] + HIT_W'(1);
                    while (j > 0 && table_hits[j] > table_hits[j-1]) begin
                        tid = table_ids[j-1];
                        th  = table_hits[j-1];
                        table_ids[j-1]  = table_ids[j];
                        table_hits[j-1] = table_hits[j];
                        table_ids[j]    = tid;
                        table_hits[j]   = th;
                        j--;
                    end
                end
                return;
            end
        end
        if (fresh_cnt < QUEUE_SLOTS) begin
            fresh_ids[fresh_cnt] = id;
            fresh_cnt++;
        end
    endfunction

    // Closing a batch: when the front entry sits exactly at the limit all
    // counts decay by one and the entries that fall to zero leave the tail.
    // New ids then fill the free slots with one hit each and the whole table
    // is dumped. An empty table dumps a single invalid transaction.
    function automatic void close_and_dump();
        int i;
        int idle_cnt;
        logic [HIT_W-1:0] front;
        t_out_item r;
        front = (table_used > 0) ? table_hits[0] : '0;
        if (front == hit_limit) begin
            idle_cnt = 0;
            for (i = 0; i < table_used; i++) begin
                if (table_hits[i] > 0)
                    table_hits[i] = table_hits[i] - HIT_W'(1);
                if (table_hits[i] < 1)
                    idle_cnt++;
            end
            table_used = table_used - idle_cnt;
        end
        for (i = 0; i < fresh_cnt && table_used < SLOTS; i++) begin
            table_ids[table_used]  = fresh_ids[i];
            table_hits[table_used] = HIT_W'(1);
            table_used++;
        end
        fresh_cnt = 0;
        if (table_used == 0) begin
            r = '0;
            r.last_entry = 1'b1;
            dump_expected.push_back(r);
        end else begin
            for (i = 0; i < table_used; i++) begin
                r.slot_index  = i[SLOT_W-1:0];
                r.cand_id_out = table_ids[i];
                r.hit_count   = table_hits[i];
                r.entry_valid = 1'b1;
                r.table_size  = table_used[SIZE_W-1:0];
                r.last_entry  = (i + 1 == table_used);
                dump_expected.push_back(r);
            end
        end
    endfunction

    function automatic void predict_item(t_in_item it);
        if (it.has_holder && it.holder_id != it.owner_id)
            rank_holder(it.holder_id);
        if (it.batch_end)
            close_and_dump();
    endfunction

    function automatic t_in_item make_item(logic [ID_W-1:0] holder, logic [ID_W-1:0] owner,
                                           logic has, logic last);
        t_in_item it;
        it.holder_id  = holder;
        it.owner_id   = owner;
        it.has_holder = has;
        it.batch_end  = last;
        return it;
    endfunction

    // Offers one item and waits until the block accepts it. Valid stays high after
    // acceptance so that back-to-back items need no gap; a random gap lowers
    // it first, in a step of its own.
    task automatic send_item(t_in_item it);
        if (idle_on) begin
            while ($urandom_range(99) < 23) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(it);
        if (it.batch_end || (it.has_holder && it.holder_id != it.owner_id))
            work_sent++;
    endtask

    // The sender pauses until every predicted transaction has come out, then
    // lets the block settle before anything else happens.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (dump_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The limit register is only written while the block is idle.
    task automatic write_hit_limit(logic [HIT_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hit_limit  = value;
    endtask

    // Receiver: takes each output transaction and checks it against the
    // oldest prediction, then picks its stall for the next cycle.
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dump_expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction: slot %0d id %h hits %0d",
                             o_out_item.slot_index, o_out_item.cand_id_out,
                             o_out_item.hit_count);
            end else begin
                want = dump_expected.pop_front();
                if (o_out_item.slot_index  !== want.slot_index  ||
                    o_out_item.cand_id_out !== want.cand_id_out ||
                    o_out_item.hit_count   !== want.hit_count   ||
                    o_out_item.entry_valid !== want.entry_valid ||
                    o_out_item.table_size  !== want.table_size  ||
                    o_out_item.last_entry  !== want.last_entry) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected slot %0d id %h hits %0d valid %0d ",
                                  "size %0d last %0d, got slot %0d id %h hits %0d ",
                                  "valid %0d size %0d last %0d"},
                                 want.slot_index, want.cand_id_out, want.hit_count,
                                 want.entry_valid, want.table_size, want.last_entry,
                                 o_out_item.slot_index, o_out_item.cand_id_out,
                                 o_out_item.hit_count, o_out_item.entry_valid,
                                 o_out_item.table_size, o_out_item.last_entry);
                end
            end
        end
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on) begin
            i_out_stall <= ($urandom_range(99) < 23);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Closing with no holder, and closing with only the owner, must both
    // dump the empty table.
    task automatic test_empty_close();
        send_item(make_item(32'h1111_2222, 32'h0000_0000, 1'b0, 1'b1));
        send_item(make_item(32'h3333_4444, 32'h3333_4444, 1'b1, 1'b1));
    endtask

    // New ids at both ends of the id range, a repeated new id that is queued
    // twice, and a skipped owner in the middle of the batch.
    task automatic test_new_ids();
        send_item(make_item(32'h0000_0000, 32'hAAAA_AAAA, 1'b1, 1'b0));
        send_item(make_item(32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b1, 1'b0));
        send_item(make_item(32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b1, 1'b0));
        send_item(make_item(32'h0000_0000, 32'hAAAA_AAAA, 1'b1, 1'b0));
        send_item(make_item(32'h1234_5678, 32'hAAAA_AAAA, 1'b1, 1'b1));
    endtask

    // Hits move an entry toward the front; the batch closes with an item
    // that carries no holder.
    task automatic test_hit_bubble();
        send_item(make_item(32'h1234_5678, 32'h5555_5555, 1'b1, 1'b0));
        send_item(make_item(32'h1234_5678, 32'h5555_5555, 1'b1, 1'b0));
        send_item(make_item(32'hFFFF_FFFF, 32'h5555_5555, 1'b1, 1'b0));
        send_item(make_item(32'hDEAD_BEEF, 32'h5555_5555, 1'b0, 1'b1));
    endtask

    // Ten new ids overflow the pending queue, and the table has fewer free
    // slots than the queue holds.
    task automatic test_pending_overflow();
        for (int k = 0; k < 10; k++)
            send_item(make_item(32'h0000_0100 + k, 32'h0F0F_0F0F, 1'b1, k == 9));
    endtask

    // A limit below the front count stops only the front entry's raise; a
    // limit equal to it triggers the decay and drops the tail of ones.
    task automatic test_saturation();
        write_hit_limit(8'd2);
        send_item(make_item(32'h1234_5678, 32'h0000_0001, 1'b1, 1'b0));
        send_item(make_item(32'h0000_0100, 32'h0000_0001, 1'b1, 1'b1));
        write_hit_limit(8'd3);
        send_item(make_item(32'h0000_0000, 32'h0000_0001, 1'b0, 1'b1));
    endtask

    // The receiver holds off for a long stretch while short batches keep
    // coming, so the output register fills and the input stalls.
    task automatic test_output_holdoff();
        wait_drained();
        idle_on = 1'b0;
        hold_tag++;
        for (int b = 0; b < 3; b++)
            for (int k = 0; k < 4; k++)
                send_item(make_item(32'h0000_0100 + $urandom_range(0, 7),
                                    32'h0000_0103, 1'b1, k == 3));
        wait_drained();
        idle_on = 1'b1;
    endtask

    // One random batch: mostly ids from a small pool, biased toward its head
    // so that hits pile up, with some owner items, holderless noise and
    // fully random ids mixed in.
    task automatic random_batch();
        int len;
        int r;
        logic [ID_W-1:0] owner;
        logic [ID_W-1:0] holder;
        logic has;
        logic last;
        len   = $urandom_range(1, 10);
        owner = ($urandom_range(3) == 0) ? $urandom() : id_pool[$urandom_range(0, POOL_N-1)];
        for (int k = 0; k < len; k++) begin
            r      = $urandom_range(99);
            has    = 1'b1;
            last   = (k == len - 1);
            holder = id_pool[$urandom_range(0, $urandom_range(0, POOL_N-1))];
            if (r < 8) begin
                has    = 1'b0;
                holder = $urandom();
            end else if (r < 16) begin
                holder = owner;
            end else if (r < 26) begin
                holder = $urandom();
            end
            send_item(make_item(holder, owner, has, last));
        end
    endtask

    // Random phases across several limits, the extremes among them, one of
    // them run with no idling on either side.
    task automatic test_random_phases();
        logic [HIT_W-1:0] limits [5];
        int phase_goal;
        limits = '{8'd1, 8'd255, 8'd4, 8'd2, 8'd8};
        for (int p = 0; p < 5; p++) begin
            write_hit_limit(limits[p]);
            for (int n = 0; n < POOL_N; n++)
                id_pool[n] = $urandom();
            id_pool[POOL_N-1] = (p % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
            idle_on    = (p != 2);
            phase_goal = work_sent + RANDOM_ITEMS / 5;
            while (work_sent < phase_goal)
                random_batch();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        table_used = 0;
        fresh_cnt  = 0;
        hit_limit  = MAX_HITS_RST;
        for (int n = 0; n < SLOTS; n++)
            table_hits[n] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_close();
        test_new_ids();
        test_hit_bubble();
        test_pending_overflow();
        test_saturation();
        test_output_holdoff();
        test_random_phases();

        // Everything has been offered; let the last dump come out and give
        // any stray transaction the chance to show up.
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && dump_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
